/* hw/rtl/gga_position_field_extractor_top_defines.svh */
// Assertion macros shared by the GGA position field extractor RTL.
`ifndef GGA_POSITION_FIELD_EXTRACTOR_TOP_DEFINES_SVH
`define GGA_POSITION_FIELD_EXTRACTOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication: cons must hold whenever ante holds.
`define GPFE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");
// Next-cycle implication: cons must hold in the cycle after ante.
`define GPFE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define GPFE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GPFE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/gpfe_pkg.sv */
// Types and constants shared by the GGA position field extractor.
package gpfe_pkg;

    // Header "$GPGGA," and framing characters
    localparam int          HDR_LEN     = 7;
    localparam int          HDR_IW      = 3;
    localparam logic [7:0]  ASCII_COMMA = 8'h2C;
    localparam logic [7:0]  ASCII_0     = 8'h30;
    localparam logic [7:0]  ASCII_9     = 8'h39;
    localparam logic [7:0]  FRAME_START = 8'h2A;
    localparam logic [7:0]  FRAME_STOP  = 8'h21;

    // Commas already seen when the closing comma of each field arrives
    localparam logic [2:0]  COMMA_LAT_END = 3'd1;
    localparam logic [2:0]  COMMA_LON_END = 3'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic hdr_adv;
        logic hdr_clr;
        logic cap_start;
        logic lat_wr;
        logic lon_wr;
        logic comma_inc;
        logic comma_clr;
        logic emit_step;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic hdr_match;
        logic hdr_last;
        logic is_comma;
        logic lat_done;
        logic lon_done;
        logic fix_ok;
        logic emit_last;
        logic out_free;
    } t_sts;

    // Expected header character at a given match position
    function automatic logic [7:0] hdr_char(input logic [HDR_IW-1:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h24;  // '$'
            3'd1:    c = 8'h47;  // 'G'
            3'd2:    c = 8'h50;  // 'P'
            3'd3:    c = 8'h47;  // 'G'
            3'd4:    c = 8'h47;  // 'G'
            3'd5:    c = 8'h41;  // 'A'
            3'd6:    c = 8'h2C;  // ','
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/gga_position_field_extractor_top.sv */
// Top level of the GGA position field extractor: controller plus datapath.
//
//  Channel   Valid        Stall        Payload
//  input     i_in_valid   o_in_stall   i_rx_byte[7:0]
//  output    o_out_valid  i_out_stall  o_tx_byte[7:0], o_frame_end
//
// Each input byte causes no output, except the comma that closes the
// longitude hemisphere field when latitude starts with a digit.
// That byte starts a frame of LAT_BYTES + LON_BYTES + 2 bytes, sent one per
// cycle through the output register while not stalled; input stall stays
// high until the last byte is loaded, longer while the output is stalled.
// Reset is synchronous, active low, and needs no clearing pass.
module gga_position_field_extractor_top #(
    parameter int LAT_BYTES = 11,
    parameter int LON_BYTES = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_tx_byte,
    output logic       o_frame_end
);
    import gpfe_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sentence phase state machine
    gpfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Stores, counters and frame output
    gpfe_dp #(
        .LAT_BYTES (LAT_BYTES),
        .LON_BYTES (LON_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_rx_byte   (i_rx_byte),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_tx_byte   (o_tx_byte),
        .o_frame_end (o_frame_end)
    );

endmodule

/* hw/rtl/gpfe_ctrl.sv */
// Sentence phase controller for the GGA position field extractor.
`include "gga_position_field_extractor_top_defines.svh"

module gpfe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  gpfe_pkg::t_sts  i_sts,
    output gpfe_pkg::t_cmd  o_cmd
);
    import gpfe_pkg::*;

    typedef enum logic [2:0] {
        S_HEADER,
        S_SKIP,
        S_LAT,
        S_LON,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_stall, n_stall;
    logic   w_fire;

    assign w_fire     = i_in_valid & ~r_stall;
    assign o_in_stall = r_stall;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_stall = r_stall;
        o_cmd   = '0;
        unique case (r_state)
            S_HEADER: begin
                if (w_fire) begin
                    if (i_sts.hdr_match && i_sts.hdr_last) begin
                        o_cmd.hdr_clr = 1'b1;
                        n_state       = S_SKIP;
                    end else if (i_sts.hdr_match) begin
                        o_cmd.hdr_adv = 1'b1;
                    end else begin
                        o_cmd.hdr_clr = 1'b1;
                    end
                end
            end
            S_SKIP: begin
                if (w_fire && i_sts.is_comma) begin
                    o_cmd.cap_start = 1'b1;
                    n_state         = S_LAT;
                end
            end
            S_LAT: begin
                if (w_fire) begin
                    if (i_sts.is_comma) begin
                        o_cmd.comma_inc = 1'b1;
                        if (i_sts.lat_done) begin
                            n_state = S_LON;
                        end
                    end else begin
                        o_cmd.lat_wr = 1'b1;
                    end
                end
            end
            S_LON: begin
                if (w_fire) begin
                    if (i_sts.is_comma && i_sts.lon_done) begin
                        o_cmd.comma_clr = 1'b1;
                        o_cmd.hdr_clr   = 1'b1;
                        if (i_sts.fix_ok) begin
                            n_state = S_EMIT;
                            n_stall = 1'b1;
                        end else begin
                            n_state = S_HEADER;
                        end
                    end else if (i_sts.is_comma) begin
                        o_cmd.comma_inc = 1'b1;
                    end else begin
                        o_cmd.lon_wr = 1'b1;
                    end
                end
            end
            S_EMIT: begin
                // one frame byte per free output slot
                if (i_sts.out_free) begin
                    o_cmd.emit_step = 1'b1;
                    if (i_sts.emit_last) begin
                        n_state = S_HEADER;
                        n_stall = 1'b0;
                    end
                end
            end
            default: begin
                o_cmd.hdr_clr   = 1'b1;
                o_cmd.comma_clr = 1'b1;
                n_state         = S_HEADER;
                n_stall         = 1'b0;
            end
        endcase
    end

    // State and registered stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HEADER;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= n_stall;
        end
    end

    `GPFE_ASSERT_IMP(a_stall_iff_emit, i_clk, i_rst_n, r_stall != (r_state == S_EMIT), 1'b0)
    `GPFE_ASSERT_NXT(a_fix_starts_emit, i_clk, i_rst_n, r_state == S_LON && w_fire && i_sts.is_comma && i_sts.lon_done && i_sts.fix_ok, r_state == S_EMIT)
    `GPFE_ASSERT_NXT(a_emit_done_returns, i_clk, i_rst_n, r_state == S_EMIT && i_sts.out_free && i_sts.emit_last, r_state == S_HEADER && !r_stall)

endmodule

/* hw/rtl/gpfe_dp.sv */
// Datapath: header matcher, field stores, comma counter and frame output register.
`include "gga_position_field_extractor_top_defines.svh"

module gpfe_dp #(
    parameter int LAT_BYTES = 11,
    parameter int LON_BYTES = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gpfe_pkg::t_cmd  i_cmd,
    output gpfe_pkg::t_sts  o_sts,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output logic [7:0]      o_tx_byte,
    output logic            o_frame_end
);
    import gpfe_pkg::*;

    localparam int FRAME_LEN = LAT_BYTES + LON_BYTES + 2;
    localparam int EW        = $clog2(FRAME_LEN);
    localparam int LAT_IW    = $clog2(LAT_BYTES);
    localparam int LON_IW    = $clog2(LON_BYTES);
    localparam int LAT_FW    = $clog2(LAT_BYTES + 1);
    localparam int LON_FW    = $clog2(LON_BYTES + 1);

    logic [HDR_IW-1:0] r_hdr_idx;
    logic [2:0]        r_comma_cnt;
    logic [LAT_FW-1:0] r_lat_fill;
    logic [LON_FW-1:0] r_lon_fill;
    logic [EW-1:0]     r_emit_idx;
    logic              r_out_valid;
    logic [7:0]        r_tx_byte;
    logic              r_frame_end;
    logic [7:0]        r_lat [LAT_BYTES];
    logic [7:0]        r_lon [LON_BYTES];

    logic [EW-1:0]     w_lat_off;
    logic [EW-1:0]     w_lon_off;
    logic [7:0]        w_frame_byte;
    logic              w_lat_room;
    logic              w_lon_room;

    // Status toward the controller
    assign o_sts.hdr_match = (i_rx_byte == hdr_char(r_hdr_idx));
    assign o_sts.hdr_last  = (r_hdr_idx == HDR_IW'(HDR_LEN - 1));
    assign o_sts.is_comma  = (i_rx_byte == ASCII_COMMA);
    assign o_sts.lat_done  = (r_comma_cnt >= COMMA_LAT_END);
    assign o_sts.lon_done  = (r_comma_cnt >= COMMA_LON_END);
    assign o_sts.fix_ok    = (r_lat[0] >= ASCII_0) && (r_lat[0] <= ASCII_9);
    assign o_sts.emit_last = (r_emit_idx == EW'(FRAME_LEN - 1));
    assign o_sts.out_free  = ~r_out_valid | ~i_out_stall;

    assign w_lat_room = (r_lat_fill < LAT_FW'(LAT_BYTES));
    assign w_lon_room = (r_lon_fill < LON_FW'(LON_BYTES));

    // Frame byte for the current emit position
    assign w_lat_off = r_emit_idx - EW'(1);
    assign w_lon_off = r_emit_idx - EW'(LAT_BYTES + 1);
    always_comb begin
        if (r_emit_idx == '0) begin
            w_frame_byte = FRAME_START;
        end else if (r_emit_idx <= EW'(LAT_BYTES)) begin
            w_frame_byte = r_lat[w_lat_off[LAT_IW-1:0]];
        end else if (r_emit_idx <= EW'(LAT_BYTES + LON_BYTES)) begin
            w_frame_byte = r_lon[w_lon_off[LON_IW-1:0]];
        end else begin
            w_frame_byte = FRAME_STOP;
        end
    end

    // Counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx   <= '0;
            r_comma_cnt <= '0;
            r_lat_fill  <= '0;
            r_lon_fill  <= '0;
            r_emit_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.hdr_clr) begin
                r_hdr_idx <= '0;
            end else if (i_cmd.hdr_adv) begin
                r_hdr_idx <= r_hdr_idx + HDR_IW'(1);
            end

            if (i_cmd.cap_start || i_cmd.comma_clr) begin
                r_comma_cnt <= '0;
            end else if (i_cmd.comma_inc) begin
                r_comma_cnt <= r_comma_cnt + 3'd1;
            end

            if (i_cmd.cap_start) begin
                r_lat_fill <= '0;
                r_lon_fill <= '0;
            end else begin
                if (i_cmd.lat_wr && w_lat_room) begin
                    r_lat_fill <= r_lat_fill + LAT_FW'(1);
                end
                if (i_cmd.lon_wr && w_lon_room) begin
                    r_lon_fill <= r_lon_fill + LON_FW'(1);
                end
            end

            if (i_cmd.emit_step) begin
                r_emit_idx <= o_sts.emit_last ? '0 : r_emit_idx + EW'(1);
            end

            if (o_sts.out_free) begin
                r_out_valid <= i_cmd.emit_step;
            end
        end
    end

    // Field stores and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_start) begin
            for (int i = 0; i < LAT_BYTES; i++) begin
                r_lat[i] <= '0;
            end
            for (int i = 0; i < LON_BYTES; i++) begin
                r_lon[i] <= '0;
            end
        end else begin
            if (i_cmd.lat_wr && w_lat_room) begin
                r_lat[r_lat_fill[LAT_IW-1:0]] <= i_rx_byte;
            end
            if (i_cmd.lon_wr && w_lon_room) begin
                r_lon[r_lon_fill[LON_IW-1:0]] <= i_rx_byte;
            end
        end
        if (i_cmd.emit_step) begin
            r_tx_byte   <= w_frame_byte;
            r_frame_end <= o_sts.emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tx_byte   = r_tx_byte;
    assign o_frame_end = r_frame_end;

    `GPFE_ASSERT_NXT(a_lat_full_holds, i_clk, i_rst_n, i_cmd.lat_wr && !w_lat_room && !i_cmd.cap_start, r_lat_fill == LAT_FW'(LAT_BYTES))
    `GPFE_ASSERT_IMP(a_end_is_stop, i_clk, i_rst_n, r_out_valid && r_frame_end, r_tx_byte == FRAME_STOP)
    `GPFE_ASSERT_NXT(a_emit_wraps, i_clk, i_rst_n, i_cmd.emit_step && o_sts.emit_last, r_emit_idx == '0 && r_out_valid && r_frame_end)

endmodule

/* dv/gpfe_frame_checker.sv */
// Checker for the GGA position field extractor: predicts frames and compares output bytes.
`timescale 1ns / 100ps

module gpfe_frame_checker #(
    parameter int LAT_BYTES = 11,
    parameter int LON_BYTES = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_tx_byte,
    input  logic       i_frame_end,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_bytes_checked,
    output int         o_frames_predicted
);
    import gpfe_pkg::*;

    typedef enum logic [1:0] {
        SEEK_HEADER,
        SKIP_TIME,
        TAKE_LAT,
        TAKE_LON
    } t_parse_phase;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_end;
    } t_frame_byte;

    // Sentence tag, first character in the top byte
    localparam logic [8*HDR_LEN-1:0] GGA_TAG = "$GPGGA,";

    // Parser mirror
    t_parse_phase parse_phase  = SEEK_HEADER;
    logic [2:0]   tag_pos      = '0;
    logic [2:0]   field_commas = '0;
    logic [7:0]   lat_chars [LAT_BYTES];
    logic [7:0]   lon_chars [LON_BYTES];
    int           lat_count    = 0;
    int           lon_count    = 0;

    // Frame bytes predicted but not yet seen on the output
    t_frame_byte  frame_bytes_due [$];

    initial begin
        foreach (lat_chars[i]) lat_chars[i] = '0;
        foreach (lon_chars[i]) lon_chars[i] = '0;
        o_fail_count       = 0;
        o_pending          = 0;
        o_bytes_checked    = 0;
        o_frames_predicted = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        o_fail_count++;
    endtask

    // Queue the whole position frame built from the current stores
    task automatic queue_position_frame();
        frame_bytes_due.push_back('{tx_byte: FRAME_START, frame_end: 1'b0});
        for (int i = 0; i < LAT_BYTES; i++)
            frame_bytes_due.push_back('{tx_byte: lat_chars[i], frame_end: 1'b0});
        for (int i = 0; i < LON_BYTES; i++)
            frame_bytes_due.push_back('{tx_byte: lon_chars[i], frame_end: 1'b0});
        frame_bytes_due.push_back('{tx_byte: FRAME_STOP, frame_end: 1'b1});
        o_frames_predicted++;
    endtask

    // Advance the parser mirror by one received character
    task automatic absorb_rx_char(input logic [7:0] c);
        case (parse_phase)
            SEEK_HEADER: begin
                if (c == GGA_TAG[8*(HDR_LEN-1-tag_pos) +: 8]) begin
                    if (tag_pos == 3'(HDR_LEN - 1)) begin
                        tag_pos     = '0;
                        parse_phase = SKIP_TIME;
                    end else begin
                        tag_pos = tag_pos + 3'd1;
                    end
                end else begin
                    // a stray '$' also lands here and does not restart the match
                    tag_pos = '0;
                end
            end
            SKIP_TIME: begin
                if (c == ASCII_COMMA) begin
                    foreach (lat_chars[i]) lat_chars[i] = '0;
                    foreach (lon_chars[i]) lon_chars[i] = '0;
                    lat_count    = 0;
                    lon_count    = 0;
                    field_commas = '0;
                    parse_phase  = TAKE_LAT;
                end
            end
            TAKE_LAT: begin
                if (c == ASCII_COMMA) begin
                    field_commas = field_commas + 3'd1;
                    if (field_commas > COMMA_LAT_END) parse_phase = TAKE_LON;
                end else if (lat_count < LAT_BYTES) begin
                    lat_chars[lat_count] = c;
                    lat_count++;
                end
            end
            TAKE_LON: begin
                if (c == ASCII_COMMA) begin
                    field_commas = field_commas + 3'd1;
                    if (field_commas > COMMA_LON_END) begin
                        // frame only when latitude opens with a digit
                        if (lat_chars[0] >= ASCII_0 && lat_chars[0] <= ASCII_9)
                            queue_position_frame();
                        field_commas = '0;
                        tag_pos      = '0;
                        parse_phase  = SEEK_HEADER;
                    end
                end else if (lon_count < LON_BYTES) begin
                    lon_chars[lon_count] = c;
                    lon_count++;
                end
            end
            default: begin
                parse_phase  = SEEK_HEADER;
                tag_pos      = '0;
                field_commas = '0;
            end
        endcase
    endtask

    // Compare one output transaction with the oldest predicted byte
    task automatic check_frame_byte(input logic [7:0] b, input logic e);
        t_frame_byte due;
        if (frame_bytes_due.size() == 0) begin
            report_mismatch($sformatf("output byte 0x%02h with no frame pending", b));
        end else begin
            due = frame_bytes_due.pop_front();
            if (b !== due.tx_byte)
                report_mismatch($sformatf("tx_byte 0x%02h, expected 0x%02h",
                                          b, due.tx_byte));
            if (e !== due.frame_end)
                report_mismatch($sformatf("frame_end %b, expected %b on byte 0x%02h",
                                          e, due.frame_end, due.tx_byte));
            o_bytes_checked++;
        end
    endtask

    // Output side first: a byte accepted at this edge cannot belong to this edge's input
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) check_frame_byte(i_tx_byte, i_frame_end);
            if (i_in_valid && !i_in_stall) absorb_rx_char(i_rx_byte);
        end
        o_pending = frame_bytes_due.size();
    end

endmodule

/* dv/tb_gga_position_field_extractor_top.sv */
// Testbench top for the GGA position field extractor: sentence stimulus, flow control, verdict.
`timescale 1ns / 100ps

module tb_gga_position_field_extractor_top;
    import gpfe_pkg::*;

    localparam int LAT_BYTES    = 11;
    localparam int LON_BYTES    = 12;
    localparam int TARGET_BYTES = 280;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 40;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] rx_byte   = '0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] tx_byte;
    logic       frame_end;

    int fail_count;
    int pending;
    int bytes_checked;
    int frames_predicted;

    int src_idle_pct   = 0;
    int dst_stall_pct  = 0;
    int sent_bytes     = 0;
    int sentence_bytes = 0;
    int sentences      = 0;
    int idle_cycles    = 0;

    // Characters of the line being built
    logic [7:0] line_q [$];

    gga_position_field_extractor_top #(
        .LAT_BYTES (LAT_BYTES),
        .LON_BYTES (LON_BYTES)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_rx_byte   (rx_byte),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_tx_byte   (tx_byte),
        .o_frame_end (frame_end)
    );

    gpfe_frame_checker #(
        .LAT_BYTES (LAT_BYTES),
        .LON_BYTES (LON_BYTES)
    ) u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_rx_byte          (rx_byte),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_tx_byte          (tx_byte),
        .i_frame_end        (frame_end),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_bytes_checked    (bytes_checked),
        .o_frames_predicted (frames_predicted)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver back-pressure
    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < dst_stall_pct);
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Any field character but the comma, with the all-zero and all-one bytes favored
    function automatic logic [7:0] field_char();
        logic [7:0] c;
        case ($urandom_range(0, 15))
            0:       c = 8'h00;
            1:       c = 8'hFF;
            default: c = 8'($urandom_range(0, 255));
        endcase
        if (c == ASCII_COMMA) c = 8'hAC;
        return c;
    endfunction

    // First latitude character: a digit for a fix, else a random non-digit, '/' or ':' for a digit
    function automatic logic [7:0] lat_lead(input bit fix);
        logic [7:0] c;
        if (fix) begin
            c = ASCII_0 + 8'($urandom_range(0, 9));
        end else begin
            c = field_char();
            if (c >= ASCII_0 && c <= ASCII_9)
                c = $urandom_range(0, 1) ? ASCII_0 - 8'd1 : ASCII_9 + 8'd1;
        end
        return c;
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    endtask

    task automatic add_chars(input int n);
        repeat (n) line_q.push_back(field_char());
    endtask

    task automatic add_fill(input int n, input logic [7:0] c);
        repeat (n) line_q.push_back(c);
    endtask

    // One input transaction, with random idle cycles in front
    task automatic push_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= c;
        do @(posedge clk); while (in_stall);
    endtask

    // Send the built line; flow-control phase follows progress through the byte budget
    task automatic send_line(input bit is_sentence);
        case (sent_bytes * 4 / TARGET_BYTES)
            0:       begin src_idle_pct = 0;  dst_stall_pct = 0;  end
            1:       begin src_idle_pct = 79; dst_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  dst_stall_pct = 79; end
            default: begin src_idle_pct = 9;  dst_stall_pct = 9;  end
        endcase
        foreach (line_q[i]) push_char(line_q[i]);
        sent_bytes += line_q.size();
        if (is_sentence) begin
            sentence_bytes += line_q.size();
            sentences++;
        end
        line_q.delete();
    endtask

    // Well-formed GGA head with random time, latitude and longitude contents
    task automatic build_gga();
        bit fix;
        int lat_len;
        fix     = ($urandom_range(0, 7) != 0);
        lat_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, LAT_BYTES + 2);
        add_text("$GPGGA,");
        add_chars($urandom_range(0, 10));
        add_text(",");
        if (lat_len > 0) begin
            line_q.push_back(lat_lead(fix));
            add_chars(lat_len - 1);
        end
        add_text(",");
        add_chars($urandom_range(0, 2));
        add_text(",");
        add_chars($urandom_range(0, LON_BYTES + 2));
        add_text(",");
        add_chars($urandom_range(0, 2));
        add_text(",");
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Doubled '$' must not start a match; the field data after it is ignored
        add_text("$$GPGGA,1,2,3,4,");
        send_line(0);
        // Surplus characters in both fields, all-ones latitude, zero and high-bit longitude
        add_text("$GPGGA,123519,9");
        add_fill(LAT_BYTES, 8'hFF);
        add_text(",N,");
        add_fill(LON_BYTES / 2, 8'h00);
        add_fill(LON_BYTES / 2 + 2, 8'h80);
        add_text(",W,");
        send_line(1);
        // Stores cleared at capture start: only the '0' survives
        add_text("$GPGGA,,0,,,,");
        send_line(1);
        // Characters just outside the digit range: no frame
        add_text("$GPGGA,0,/,N,1,E,");
        send_line(1);
        add_text("$GPGGA,0,:,N,1,E,");
        send_line(1);
        // Empty latitude; hemisphere digit becomes the first latitude byte
        add_text("$GPGGA,,,9,,,");
        send_line(1);

        // Random part: mostly full sentences, some cut short, some line noise
        while (sent_bytes < TARGET_BYTES) begin
            case ($urandom_range(0, 9))
                0: begin
                    case ($urandom_range(0, 2))
                        0:       add_chars($urandom_range(1, 8));
                        1:       begin add_text("$GPGG"); add_chars(1); end
                        default: add_text("$GPGGB,");
                    endcase
                    send_line(0);
                end
                1: begin
                    build_gga();
                    repeat ($urandom_range(1, line_q.size() - 8)) void'(line_q.pop_back());
                    send_line(1);
                end
                default: begin
                    build_gga();
                    send_line(1);
                    if ($urandom_range(0, 1)) begin
                        add_text("1,08,0.9,545.4,M,46.9,M,,*47");
                        add_fill(1, 8'h0D);
                        add_fill(1, 8'h0A);
                        send_line(0);
                    end
                end
            endcase
        end
        in_valid <= 1'b0;

        // Drain outstanding frame bytes, then let the block settle
        do @(posedge clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d bytes, %0d of them in %0d sentences, across four flow-control phases;",
                 sent_bytes, sentence_bytes, sentences);
        $display("%0d frames predicted, %0d frame bytes compared.",
                 frames_predicted, bytes_checked);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
